// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file lav_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/lav_pkg.sv -----
// Shared constants and types of the look-at view matrix pipeline.
`default_nettype none
package lav_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int UNIT_W = 32;     // Q2.30 unit component
	localparam int MAG_W = 30;      // normalised magnitude
	localparam int SQ_W = 62;       // sum of three squares
	localparam int ROOT_W = 31;     // integer square root bits
	localparam int QUO_W = 31;      // quotient bits, up to 2^30
	localparam int PROD_W = 64;     // cross product term
	localparam int CX_W = 65;       // cross product component
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;

	localparam logic [47:0] UP_Y_RESET = 48'd65536;

	typedef logic [2:0][UNIT_W-1:0] unit_vec_t;
endpackage
`default_nettype wire

// ----- sv/lav_norm.sv -----
// Scales a signed 3-vector so its largest magnitude has exactly 30 bits.
`default_nettype none
module lav_norm import lav_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0][W-1:0]     v,
	output logic [2:0][MAG_W-1:0] mag,
	output logic [2:0]            neg,
	output logic                  zero
);
	localparam int BL_W = $clog2(W + 1);

	logic [2:0][W-1:0] abs_c;
	logic [W-1:0]      max_c;
	logic [2:0][W-1:0] mag_s1, mag_s2;
	logic [W-1:0]      max_s1;
	logic [2:0]        neg_s1, neg_s2;
	logic [BL_W-1:0]   bl_c, bl_s2;
	logic              zero_s2;

	always_comb begin
		for (int i = 0; i < 3; i++)
			abs_c[i] = v[i][W-1] ? -v[i] : v[i];
		max_c = abs_c[0];
		if (abs_c[1] > max_c)
			max_c = abs_c[1];
		if (abs_c[2] > max_c)
			max_c = abs_c[2];
	end

	// bit length of the largest magnitude
	always_comb begin
		bl_c = '0;
		for (int i = 0; i < W; i++)
			if (max_s1[i])
				bl_c = BL_W'(i + 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= abs_c;
			max_s1  <= max_c;
			for (int i = 0; i < 3; i++)
				neg_s1[i] <= v[i][W-1];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			bl_s2   <= bl_c;
			zero_s2 <= (max_s1 == '0);
			// mag * 2^30 / 2^bl: left or right shift in one step
			for (int i = 0; i < 3; i++)
				mag[i] <= MAG_W'({mag_s2[i], {MAG_W{1'b0}}} >> bl_s2);
			neg  <= neg_s2;
			zero <= zero_s2;
		end
	end
endmodule
`default_nettype wire

// ----- sv/lav_unitize.sv -----
// Pipelined unit vector: normalise, square root, three dividers.
`default_nettype none
module lav_unitize import lav_pkg::*; #(
	parameter int IN_W   = 33,
	parameter int SIDE_W = 96
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][IN_W-1:0] v,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_valid,
	output unit_vec_t            u,
	output logic [SIDE_W-1:0]    side_out
);
	localparam int NORM_LAT = 3;
	localparam int SQ1_W = 2 * MAG_W;

	logic [2:0][MAG_W-1:0] n_mag;
	logic [2:0]            n_neg;
	logic                  n_zero;

	lav_norm #(.W(IN_W)) u_norm (
		.clk  (clk),
		.en   (en),
		.v    (v),
		.mag  (n_mag),
		.neg  (n_neg),
		.zero (n_zero)
	);

	// valid and side data alongside the normaliser
	logic [1:NORM_LAT]  nvld_s;
	logic [SIDE_W-1:0]  nside_s [1:NORM_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nvld_s <= '0;
		else if (en)
			nvld_s <= {in_valid, nvld_s[1:NORM_LAT-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nside_s[1] <= side_in;
			for (int k = 2; k <= NORM_LAT; k++)
				nside_s[k] <= nside_s[k-1];
		end
	end

	// squares
	logic                  sq_vld_s;
	logic [2:0][SQ1_W-1:0] sq_s;
	logic [2:0][MAG_W-1:0] sq_mag_s;
	logic [2:0]            sq_neg_s;
	logic                  sq_zero_s;
	logic [SIDE_W-1:0]     sq_side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld_s <= 1'b0;
		else if (en)
			sq_vld_s <= nvld_s[NORM_LAT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s[i] <= n_mag[i] * n_mag[i];
			sq_mag_s  <= n_mag;
			sq_neg_s  <= n_neg;
			sq_zero_s <= n_zero;
			sq_side_s <= nside_s[NORM_LAT];
		end
	end

	// square root, one result bit per stage; stage 0 holds the sum
	logic [SQ_W-1:0]       rt_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]     rt_root_s [0:ROOT_W];
	logic [2:0][MAG_W-1:0] rt_mag_s  [0:ROOT_W];
	logic [2:0]            rt_neg_s  [0:ROOT_W];
	logic                  rt_zero_s [0:ROOT_W];
	logic                  rt_vld_s  [0:ROOT_W];
	logic [SIDE_W-1:0]     rt_side_s [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rt_vld_s[0] <= 1'b0;
		else if (en)
			rt_vld_s[0] <= sq_vld_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0]  <= SQ_W'(sq_s[0]) + SQ_W'(sq_s[1]) + SQ_W'(sq_s[2]);
			rt_root_s[0] <= '0;
			rt_mag_s[0]  <= sq_mag_s;
			rt_neg_s[0]  <= sq_neg_s;
			rt_zero_s[0] <= sq_zero_s;
			rt_side_s[0] <= sq_side_s;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_W-1:0] trial;
		logic            take;

		// (root + 2^B)^2 - root^2
		assign trial = (SQ_W'(rt_root_s[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
		assign take  = (rt_rem_s[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rt_vld_s[k+1] <= 1'b0;
			else if (en)
				rt_vld_s[k+1] <= rt_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k+1]  <= take ? rt_rem_s[k] - trial : rt_rem_s[k];
				rt_root_s[k+1] <= take ? (rt_root_s[k] | (ROOT_W'(1) << B)) : rt_root_s[k];
				rt_mag_s[k+1]  <= rt_mag_s[k];
				rt_neg_s[k+1]  <= rt_neg_s[k];
				rt_zero_s[k+1] <= rt_zero_s[k];
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// division (mag * 2^30 + len/2) / len, one quotient bit per stage
	logic [2:0][SQ_W-1:0]  dv_rem_s  [0:QUO_W];
	logic [2:0][QUO_W-1:0] dv_quo_s  [0:QUO_W];
	logic [ROOT_W-1:0]     dv_len_s  [0:QUO_W];
	logic [2:0]            dv_neg_s  [0:QUO_W];
	logic                  dv_zero_s [0:QUO_W];
	logic                  dv_vld_s  [0:QUO_W];
	logic [SIDE_W-1:0]     dv_side_s [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (en)
			dv_vld_s[0] <= rt_vld_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				dv_rem_s[0][j] <= (SQ_W'(rt_mag_s[ROOT_W][j]) << MAG_W)
					+ SQ_W'(rt_root_s[ROOT_W] >> 1);
			dv_quo_s[0]  <= '0;
			dv_len_s[0]  <= rt_root_s[ROOT_W];
			dv_neg_s[0]  <= rt_neg_s[ROOT_W];
			dv_zero_s[0] <= rt_zero_s[ROOT_W];
			dv_side_s[0] <= rt_side_s[ROOT_W];
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int B = QUO_W - 1 - k;
		logic [SQ_W-1:0] dl;

		assign dl = SQ_W'(dv_len_s[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k+1] <= 1'b0;
			else if (en)
				dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (dv_rem_s[k][j] >= dl) begin
						dv_rem_s[k+1][j] <= dv_rem_s[k][j] - dl;
						dv_quo_s[k+1][j] <= dv_quo_s[k][j] | (QUO_W'(1) << B);
					end else begin
						dv_rem_s[k+1][j] <= dv_rem_s[k][j];
						dv_quo_s[k+1][j] <= dv_quo_s[k][j];
					end
				end
				dv_len_s[k+1]  <= dv_len_s[k];
				dv_neg_s[k+1]  <= dv_neg_s[k];
				dv_zero_s[k+1] <= dv_zero_s[k];
				dv_side_s[k+1] <= dv_side_s[k];
			end
		end
	end

	// sign, and zero for a null vector (divider ran on len = 0)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= dv_vld_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				if (dv_zero_s[QUO_W])
					u[j] <= '0;
				else if (dv_neg_s[QUO_W][j])
					u[j] <= -UNIT_W'(dv_quo_s[QUO_W][j]);
				else
					u[j] <= UNIT_W'(dv_quo_s[QUO_W][j]);
			end
			side_out <= dv_side_s[QUO_W];
		end
	end
endmodule
`default_nettype wire

// ----- sv/look_at_view_matrix.sv -----
// Right-handed look-at view matrix, fixed point, fully pipelined.
// Input channel: in_valid / in_stall carries one eye point and one target
// point (Q16.16). Output channel: out_valid / out_stall carries the side,
// true-up and back unit vectors (Q2.30) and the three translations
// (Q16.16, saturated). A transfer happens on a clock edge with valid high
// and stall low.
// Config: cfg_we writes cfg_data to the up register picked by cfg_index
// (0 up_x, 1 up_y, 2 up_z, 3 ignored); the user must write only while the pipe is empty; not enforced.
// Throughput: one transfer per cycle while no result is held by out_stall.
// The depth is set by three unit-vector stages, each dominated by the
// 31-stage square root and the 31-stage restoring dividers, one result
// bit per stage.
// Stall: the whole pipe holds while a result waits and out_stall is high;
// in_stall follows from that, so nothing is dropped or repeated.
// Reset: clears all valid bits and sets up to (0, 1.0, 0); the scaled up
// vector settles once a reset or write has passed the up normaliser.
`default_nettype none
module look_at_view_matrix import lav_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] eye_x,
	input  logic signed [COORD_WIDTH-1:0] eye_y,
	input  logic signed [COORD_WIDTH-1:0] eye_z,
	input  logic signed [COORD_WIDTH-1:0] target_x,
	input  logic signed [COORD_WIDTH-1:0] target_y,
	input  logic signed [COORD_WIDTH-1:0] target_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [UNIT_W-1:0]      side_x,
	output logic signed [UNIT_W-1:0]      side_y,
	output logic signed [UNIT_W-1:0]      side_z,
	output logic signed [UNIT_W-1:0]      upv_x,
	output logic signed [UNIT_W-1:0]      upv_y,
	output logic signed [UNIT_W-1:0]      upv_z,
	output logic signed [UNIT_W-1:0]      back_x,
	output logic signed [UNIT_W-1:0]      back_y,
	output logic signed [UNIT_W-1:0]      back_z,
	output logic signed [COORD_WIDTH-1:0] shift_side,
	output logic signed [COORD_WIDTH-1:0] shift_upv,
	output logic signed [COORD_WIDTH-1:0] shift_fwd,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);
	localparam int CW     = COORD_WIDTH;
	localparam int EYE_W  = 3 * CW;
	localparam int VEC_W  = 3 * UNIT_W;
	localparam int H      = CW / 2;             // eye split for the multipliers
	localparam int HI_W   = CW - H;
	localparam int LO_P_W = UNIT_W + H + 1;
	localparam int HI_P_W = UNIT_W + HI_W;
	localparam int TW     = CW + 36;            // exact dot product
	localparam int XW     = TW - MAG_W;         // after the 2^30 scale
	localparam logic signed [TW-1:0] RND = TW'(1) << (MAG_W - 1);

	// Whole pipe advances unless a finished result is held back.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- configuration ----------------
	logic [CW-1:0] up_x_q, up_y_q, up_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= '0;
			up_y_q <= CW'(UP_Y_RESET);
			up_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UP_X: up_x_q <= cfg_data;
				REG_UP_Y: up_y_q <= cfg_data;
				REG_UP_Z: up_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Up vector scaled to 30-bit magnitudes, free running.
	logic [2:0][MAG_W-1:0] up_mag;
	logic [2:0]            up_neg;
	unit_vec_t             up_vec;

	lav_norm #(.W(CW)) u_up_norm (
		.clk  (clk),
		.en   (1'b1),
		.v    ({up_z_q, up_y_q, up_x_q}),
		.mag  (up_mag),
		.neg  (up_neg),
		.zero ()
	);

	always_comb begin
		for (int i = 0; i < 3; i++)
			up_vec[i] = up_neg[i] ? -UNIT_W'(up_mag[i]) : UNIT_W'(up_mag[i]);
	end

	// ---------------- stage 1: direction ----------------
	logic                  vld_s1;
	logic [2:0][CW-1:0]    eye_s1;
	logic [2:0][CW:0]      dir_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1    <= {eye_z, eye_y, eye_x};
			dir_s1[0] <= {target_x[CW-1], target_x} - {eye_x[CW-1], eye_x};
			dir_s1[1] <= {target_y[CW-1], target_y} - {eye_y[CW-1], eye_y};
			dir_s1[2] <= {target_z[CW-1], target_z} - {eye_z[CW-1], eye_z};
		end
	end

	// ---------------- forward unit vector ----------------
	logic               f_vld;
	unit_vec_t          f_u1;
	logic [2:0][CW-1:0] eye_u1;

	lav_unitize #(.IN_W(CW + 1), .SIDE_W(EYE_W)) u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.v         (dir_s1),
		.side_in   (eye_s1),
		.out_valid (f_vld),
		.u         (f_u1),
		.side_out  (eye_u1)
	);

	// ---------------- f x up ----------------
	logic signed [PROD_W-1:0] x1_p_s1 [6];
	logic                     x1_vld_s1, x1_vld_s2;
	unit_vec_t                x1_f_s1, x1_f_s2;
	logic [2:0][CW-1:0]       x1_eye_s1, x1_eye_s2;
	logic [2:0][CX_W-1:0]     x1_c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_vld_s1 <= 1'b0;
			x1_vld_s2 <= 1'b0;
		end else if (en) begin
			x1_vld_s1 <= f_vld;
			x1_vld_s2 <= x1_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_p_s1[0] <= $signed(f_u1[1]) * $signed(up_vec[2]);
			x1_p_s1[1] <= $signed(f_u1[2]) * $signed(up_vec[1]);
			x1_p_s1[2] <= $signed(f_u1[2]) * $signed(up_vec[0]);
			x1_p_s1[3] <= $signed(f_u1[0]) * $signed(up_vec[2]);
			x1_p_s1[4] <= $signed(f_u1[0]) * $signed(up_vec[1]);
			x1_p_s1[5] <= $signed(f_u1[1]) * $signed(up_vec[0]);
			x1_f_s1    <= f_u1;
			x1_eye_s1  <= eye_u1;
			x1_c_s2[0] <= CX_W'(x1_p_s1[0]) - CX_W'(x1_p_s1[1]);
			x1_c_s2[1] <= CX_W'(x1_p_s1[2]) - CX_W'(x1_p_s1[3]);
			x1_c_s2[2] <= CX_W'(x1_p_s1[4]) - CX_W'(x1_p_s1[5]);
			x1_f_s2    <= x1_f_s1;
			x1_eye_s2  <= x1_eye_s1;
		end
	end

	// ---------------- side unit vector ----------------
	logic               s_vld;
	unit_vec_t          s_u2, f_u2;
	logic [2:0][CW-1:0] eye_u2;

	lav_unitize #(.IN_W(CX_W), .SIDE_W(VEC_W + EYE_W)) u_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (x1_vld_s2),
		.v         (x1_c_s2),
		.side_in   ({x1_f_s2, x1_eye_s2}),
		.out_valid (s_vld),
		.u         (s_u2),
		.side_out  ({f_u2, eye_u2})
	);

	// ---------------- s x f ----------------
	logic signed [PROD_W-1:0] x2_p_s1 [6];
	logic                     x2_vld_s1, x2_vld_s2;
	unit_vec_t                x2_f_s1, x2_f_s2, x2_s_s1, x2_s_s2;
	logic [2:0][CW-1:0]       x2_eye_s1, x2_eye_s2;
	logic [2:0][CX_W-1:0]     x2_c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x2_vld_s1 <= 1'b0;
			x2_vld_s2 <= 1'b0;
		end else if (en) begin
			x2_vld_s1 <= s_vld;
			x2_vld_s2 <= x2_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_p_s1[0] <= $signed(s_u2[1]) * $signed(f_u2[2]);
			x2_p_s1[1] <= $signed(s_u2[2]) * $signed(f_u2[1]);
			x2_p_s1[2] <= $signed(s_u2[2]) * $signed(f_u2[0]);
			x2_p_s1[3] <= $signed(s_u2[0]) * $signed(f_u2[2]);
			x2_p_s1[4] <= $signed(s_u2[0]) * $signed(f_u2[1]);
			x2_p_s1[5] <= $signed(s_u2[1]) * $signed(f_u2[0]);
			x2_f_s1    <= f_u2;
			x2_s_s1    <= s_u2;
			x2_eye_s1  <= eye_u2;
			x2_c_s2[0] <= CX_W'(x2_p_s1[0]) - CX_W'(x2_p_s1[1]);
			x2_c_s2[1] <= CX_W'(x2_p_s1[2]) - CX_W'(x2_p_s1[3]);
			x2_c_s2[2] <= CX_W'(x2_p_s1[4]) - CX_W'(x2_p_s1[5]);
			x2_f_s2    <= x2_f_s1;
			x2_s_s2    <= x2_s_s1;
			x2_eye_s2  <= x2_eye_s1;
		end
	end

	// ---------------- true up unit vector ----------------
	logic               u_vld;
	unit_vec_t          u_u3, s_u3, f_u3;
	logic [2:0][CW-1:0] eye_u3;

	lav_unitize #(.IN_W(CX_W), .SIDE_W(2 * VEC_W + EYE_W)) u_upv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (x2_vld_s2),
		.v         (x2_c_s2),
		.side_in   ({x2_s_s2, x2_f_s2, x2_eye_s2}),
		.out_valid (u_vld),
		.u         (u_u3),
		.side_out  ({s_u3, f_u3, eye_u3})
	);

	// ---------------- translations ----------------
	// Dot products of (-s, -u, f) with eye; eye split in two halves so each
	// multiplier stays at 32 bits by about half the coordinate width.
	unit_vec_t tv [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			tv[0][j] = -s_u3[j];
			tv[1][j] = -u_u3[j];
			tv[2][j] = f_u3[j];
		end
	end

	logic signed [LO_P_W-1:0] t_lo_s1 [3][3];
	logic signed [HI_P_W-1:0] t_hi_s1 [3][3];
	logic signed [TW-1:0]     t_lo_s2 [3];
	logic signed [TW-1:0]     t_hi_s2 [3];
	logic [XW-1:0]            t_x_s3  [3];
	unit_vec_t                t_s_s1, t_s_s2, t_s_s3;
	unit_vec_t                t_u_s1, t_u_s2, t_u_s3;
	unit_vec_t                t_f_s1, t_f_s2, t_f_s3;
	logic                     t_vld_s1, t_vld_s2, t_vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_vld_s1  <= 1'b0;
			t_vld_s2  <= 1'b0;
			t_vld_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			t_vld_s1  <= u_vld;
			t_vld_s2  <= t_vld_s1;
			t_vld_s3  <= t_vld_s2;
			out_valid <= t_vld_s3;
		end
	end

	function automatic logic [CW-1:0] sat(input logic [XW-1:0] x);
		logic [XW-CW:0] top;
		logic [CW-1:0]  res;
		top = x[XW-1:CW-1];
		if (top == '0 || top == '1)
			res = x[CW-1:0];
		else if (x[XW-1])
			res = {1'b1, {(CW - 1){1'b0}}};
		else
			res = {1'b0, {(CW - 1){1'b1}}};
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int j = 0; j < 3; j++) begin
					t_lo_s1[r][j] <= $signed(tv[r][j]) * $signed({1'b0, eye_u3[j][H-1:0]});
					t_hi_s1[r][j] <= $signed(tv[r][j]) * $signed(eye_u3[j][CW-1:H]);
				end
			t_s_s1 <= s_u3;
			t_u_s1 <= u_u3;
			t_f_s1 <= f_u3;

			for (int r = 0; r < 3; r++) begin
				t_lo_s2[r] <= t_lo_s1[r][0] + t_lo_s1[r][1] + t_lo_s1[r][2];
				t_hi_s2[r] <= t_hi_s1[r][0] + t_hi_s1[r][1] + t_hi_s1[r][2];
			end
			t_s_s2 <= t_s_s1;
			t_u_s2 <= t_u_s1;
			t_f_s2 <= t_f_s1;

			// round half up, floor divide by 2^30
			for (int r = 0; r < 3; r++)
				t_x_s3[r] <= XW'(((t_hi_s2[r] <<< H) + t_lo_s2[r] + RND) >>> MAG_W);
			t_s_s3 <= t_s_s2;
			t_u_s3 <= t_u_s2;
			t_f_s3 <= t_f_s2;

			// output register
			side_x     <= t_s_s3[0];
			side_y     <= t_s_s3[1];
			side_z     <= t_s_s3[2];
			upv_x      <= t_u_s3[0];
			upv_y      <= t_u_s3[1];
			upv_z      <= t_u_s3[2];
			back_x     <= -t_f_s3[0];
			back_y     <= -t_f_s3[1];
			back_z     <= -t_f_s3[2];
			shift_side <= sat(t_x_s3[0]);
			shift_upv  <= sat(t_x_s3[1]);
			shift_fwd  <= sat(t_x_s3[2]);
		end
	end
endmodule
`default_nettype wire

// ----- sv/lav_chk.sv -----
// Port-level checks for the look-at view matrix, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lav_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] side_x,
	input logic signed [31:0] side_y,
	input logic signed [31:0] side_z,
	input logic signed [31:0] upv_x,
	input logic signed [31:0] upv_y,
	input logic signed [31:0] upv_z,
	input logic signed [31:0] back_x,
	input logic signed [31:0] back_y,
	input logic signed [31:0] back_z
);
	// input is held off exactly when a result is held back
	`ASSERT_IMP(a_stall_link, clk, arst_n, in_valid || !in_valid, in_stall == (out_valid && out_stall))

	// a held result stays put, checked on side_x and back_z
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(side_x) && $stable(back_z))

	// side_x and back_x never exceed 1.0 in magnitude
	`ASSERT_IMP(a_unit_range, clk, arst_n, out_valid, (back_x <= 32'sd1073741824) && (back_x >= -32'sd1073741824) && (side_x <= 32'sd1073741824) && (side_x >= -32'sd1073741824))

	// null forward (all-zero back) gives null side and null up
	`ASSERT_IMP(a_null_chain, clk, arst_n, out_valid && back_x == 0 && back_y == 0 && back_z == 0, side_x == 0 && side_y == 0 && side_z == 0 && upv_x == 0 && upv_y == 0 && upv_z == 0)
endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);
`default_nettype wire
